>>> sv/lcg96_lagged_sum_random_macros.svh
// Assertion macros for the lcg96 random word source.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef LCG96_LAGGED_SUM_RANDOM_MACROS_SVH
`define LCG96_LAGGED_SUM_RANDOM_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define LCG96_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lcg96 check failed");
// next-cycle implication, held off during reset
`define LCG96_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lcg96 check failed");
`else
`define LCG96_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LCG96_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> sv/lcg96_pkg.sv
// Shared constants and controller/datapath interface types for the lcg96 block.
// No dependencies.
package lcg96_pkg;

    // 96-bit multiplier 5^41, least significant word first
    localparam logic [31:0] MULT_W0    = 32'h5aa1cae5;
    localparam logic [31:0] MULT_W1    = 32'hd0cf37be;
    localparam logic [31:0] MULT_W2    = 32'h92efd1b8;

    // seed recurrence
    localparam logic [31:0] SEED_MUL   = 32'h57e32a47;
    localparam logic [31:0] SEED_ADD   = 32'h207c87a3;
    localparam logic [31:0] SEED_RESET = 32'ha897213f;

    // distance between the two summed table entries
    localparam int unsigned LAG_OFFSET = 5;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_seed;   // take a new seed from the input
        logic draw_init;   // advance seed, load LCG state, clear step count
        logic mul_en;      // register partial products of a*X
        logic add_en;      // sum partial products into the next X
        logic sum_en;      // form the result word and advance the draw index
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_step;   // current LCG step is the final one
    } t_dp_status;

endpackage

>>> sv/lcg96_dp.sv
// Datapath of the lcg96 block: seed, 96-bit LCG state, partial products,
// table entry capture and result register. Depends on lcg96_pkg.
module lcg96_dp import lcg96_pkg::*; #(
    parameter int TABLE_LEN = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd_bus,
    input  logic [31:0] i_seed_value,
    output t_dp_status  o_status,
    output logic        o_result_valid,
    output logic [31:0] o_rand_word,
    output logic        o_zero_word
);

    localparam int IW = $clog2(TABLE_LEN);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_LEN - 1);
    localparam logic [IW:0]   TL_EXT   = (IW + 1)'(TABLE_LEN);
    localparam logic [IW:0]   LAG_EXT  = (IW + 1)'(LAG_OFFSET);

    logic [31:0]   r_seed;
    logic [IW-1:0] r_draw_idx;
    logic [IW-1:0] r_step;
    logic [95:0]   r_x;
    logic [63:0]   r_p00, r_p01, r_p10;
    logic [31:0]   r_l02, r_l11, r_l20;
    logic [31:0]   r_ei, r_ej;
    logic [31:0]   r_word;
    logic          r_zero;
    logic          r_valid;

    logic [31:0]   n_seed_adv;
    logic [95:0]   n_x;
    logic [31:0]   n_entry;
    logic [31:0]   n_word;
    logic [IW:0]   lag_sum;
    logic [IW-1:0] lag_idx;

    // seed recurrence
    assign n_seed_adv = r_seed * SEED_MUL + SEED_ADD;

    // partner entry index, wrapped at the table length
    assign lag_sum = {1'b0, r_draw_idx} + LAG_EXT;
    assign lag_idx = (lag_sum >= TL_EXT) ? IW'(lag_sum - TL_EXT) : lag_sum[IW-1:0];

    // next LCG value: a*X + 1 mod 2^96 from the registered partial products
    assign n_x = 96'd1
               + {32'd0, r_p00}
               + {r_p01, 32'd0}
               + {r_p10, 32'd0}
               + {r_l02 + r_l11 + r_l20, 64'd0};

    // table entry from word 2, with the first entry forced odd
    assign n_entry = (r_step == '0) ? (n_x[95:64] | 32'd1) : n_x[95:64];

    assign n_word = r_ei + r_ej;

    assign o_status.last_step = (r_step == LAST_IDX);

    // seed, draw index and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= SEED_RESET;
            r_draw_idx <= IW'(1);
            r_step     <= '0;
        end else begin
            if (i_cmd_bus.load_seed) begin
                r_seed <= i_seed_value;
            end else if (i_cmd_bus.draw_init) begin
                r_seed <= n_seed_adv;
            end
            if (i_cmd_bus.draw_init) begin
                r_step <= '0;
            end else if (i_cmd_bus.add_en) begin
                r_step <= r_step + IW'(1);
            end
            if (i_cmd_bus.sum_en) begin
                r_draw_idx <= (r_draw_idx == LAST_IDX) ? '0 : r_draw_idx + IW'(1);
            end
        end
    end

    // LCG state, partial products and captured entries
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.draw_init) begin
            r_x <= {64'd0, n_seed_adv};
        end else if (i_cmd_bus.add_en) begin
            r_x <= n_x;
        end
        if (i_cmd_bus.mul_en) begin
            r_p00 <= {32'd0, MULT_W0} * {32'd0, r_x[31:0]};
            r_p01 <= {32'd0, MULT_W0} * {32'd0, r_x[63:32]};
            r_p10 <= {32'd0, MULT_W1} * {32'd0, r_x[31:0]};
            r_l02 <= MULT_W0 * r_x[95:64];
            r_l11 <= MULT_W1 * r_x[63:32];
            r_l20 <= MULT_W2 * r_x[31:0];
        end
        if (i_cmd_bus.add_en && (r_step == r_draw_idx)) begin
            r_ei <= n_entry;
        end
        if (i_cmd_bus.add_en && (r_step == lag_idx)) begin
            r_ej <= n_entry;
        end
        if (i_cmd_bus.sum_en) begin
            r_word <= n_word;
            r_zero <= (n_word == 32'd0);
        end
    end

    // one-cycle result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd_bus.sum_en;
        end
    end

    assign o_result_valid = r_valid;
    assign o_rand_word    = r_word;
    assign o_zero_word    = r_zero;

endmodule

>>> sv/lcg96_ctrl.sv
// Controller of the lcg96 block: command decode and the draw sequencer.
// Depends on lcg96_pkg and lcg96_lagged_sum_random_macros.svh.
`include "lcg96_lagged_sum_random_macros.svh"

module lcg96_ctrl import lcg96_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_cmd,
    input  t_dp_status i_status,
    output logic       busy,
    output t_dp_cmd    o_cmd_bus
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEED = 5'b00010,
        S_MUL  = 5'b00100,
        S_ADD  = 5'b01000,
        S_SUM  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && (i_cmd == CMD_DRAW)) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: n_state = S_MUL;
            S_MUL:  n_state = S_ADD;
            S_ADD: begin
                n_state = i_status.last_step ? S_SUM : S_MUL;
            end
            S_SUM:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // drive datapath commands
    assign busy                = (r_state != S_IDLE);
    assign o_cmd_bus.load_seed = (r_state == S_IDLE) && start && (i_cmd == CMD_LOAD);
    assign o_cmd_bus.draw_init = (r_state == S_SEED);
    assign o_cmd_bus.mul_en    = (r_state == S_MUL);
    assign o_cmd_bus.add_en    = (r_state == S_ADD);
    assign o_cmd_bus.sum_en    = (r_state == S_SUM);

    // a load transfer never occupies the sequencer
    `LCG96_ASSERT_NEXT(a_load_stays_idle, i_clk, i_rst_n, o_cmd_bus.load_seed, !busy)
    // the final step is followed by the result cycle
    `LCG96_ASSERT_NEXT(a_last_to_sum, i_clk, i_rst_n, o_cmd_bus.add_en && i_status.last_step, o_cmd_bus.sum_en)
    // every multiply cycle is followed by its add cycle
    `LCG96_ASSERT_NEXT(a_mul_then_add, i_clk, i_rst_n, o_cmd_bus.mul_en, o_cmd_bus.add_en)
    // the sequencer frees itself right after the result cycle
    `LCG96_ASSERT_NEXT(a_sum_then_idle, i_clk, i_rst_n, o_cmd_bus.sum_en, !busy)

endmodule

>>> sv/lcg96_lagged_sum_random.sv
// Top level of the lcg96 random word source.
// Depends on lcg96_pkg, lcg96_ctrl and lcg96_dp.
//
// A transfer is taken when start is high and busy is low. A load (i_cmd = 0)
// replaces the seed in that cycle; busy stays low and no result follows. A
// draw (i_cmd = 1) raises busy while it advances the seed, runs the
// TABLE_LEN steps of the 96-bit LCG (in each step a bank of 32-bit
// multipliers forms the partial products, then one wide add closes the
// step), and sums the two selected entries. The word appears on
// o_rand_word with o_zero_word for exactly one cycle, marked by
// o_result_valid, in the first cycle that busy is low again; it cannot be
// held off, so capture it then. A new transfer may be taken in that same
// cycle.
module lcg96_lagged_sum_random import lcg96_pkg::*; #(
    parameter int TABLE_LEN = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [31:0] i_seed_value,
    output logic        o_result_valid,
    output logic [31:0] o_rand_word,
    output logic        o_zero_word
);

    t_dp_cmd    cmd_bus;
    t_dp_status status;

    lcg96_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_cmd     (i_cmd),
        .i_status  (status),
        .busy      (busy),
        .o_cmd_bus (cmd_bus)
    );

    lcg96_dp #(
        .TABLE_LEN (TABLE_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .i_seed_value   (i_seed_value),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_rand_word    (o_rand_word),
        .o_zero_word    (o_zero_word)
    );

endmodule
